// File: rtl/core/fpo_pkg.sv
// ----------------------------------------------------------------------------
// fpo_pkg
// Shared widths, defaults and types for the forest position offset block.
// ----------------------------------------------------------------------------
package fpo_pkg;

    // Widths of the word fields at the ports.
    localparam int NODE_W = 64;
    localparam int IDX_W  = 6;

    // Default position width.
    localparam int POS_BITS_DEFAULT = 64;

    // Decision flags produced by the row step unit for one row.
    typedef struct packed {
        logic stop;   // node lies inside the tree of this row
        logic take;   // this row holds a tree that is passed over
    } step_flags_t;

endpackage

// File: rtl/core/fpo_step_unit.sv
// ----------------------------------------------------------------------------
// fpo_step_unit
// Shared compare and subtract unit for one row of the forest walk.
// ----------------------------------------------------------------------------
module fpo_step_unit #(
    parameter int POS_BITS = fpo_pkg::POS_BITS_DEFAULT,
    parameter int HW       = $clog2(POS_BITS),
    parameter int CW       = $clog2(POS_BITS + 1)
) (
    input  logic [POS_BITS-1:0]      marker,
    input  logic [POS_BITS-1:0]      leaves,
    input  logic [HW-1:0]            height,
    input  logic [CW-1:0]            row,
    output logic [POS_BITS-1:0]      marker_new,
    output fpo_pkg::step_flags_t     flags
);
    import fpo_pkg::*;

    localparam logic [HW-1:0] TOP_IDX = HW'(POS_BITS - 1);

    logic [POS_BITS-1:0] shifted;
    logic [POS_BITS-1:0] span;
    logic [POS_BITS-1:0] one_h;
    logic [POS_BITS-1:0] size;

    always_comb
    begin
        shifted = marker << row;
        // Ones from bit 0 up to and including the current height bit.
        span    = {POS_BITS{1'b1}} >> (TOP_IDX - height);
        one_h   = {{(POS_BITS-1){1'b0}}, 1'b1} << height;
        size    = leaves[height] ? one_h : '0;
    end

    assign flags.stop = ((shifted & span) < size);
    assign flags.take = leaves[height];
    assign marker_new = marker - size;

endmodule

// File: rtl/core/forest_position_offset.sv
// ----------------------------------------------------------------------------
// forest_position_offset
// Locates the tree, branch length and path of a node in a Merkle forest.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) takes one word holding node_pos
//   and leaf_count. The block works on that word alone and raises in_ready
//   again only once its result has been placed in the output register.
//   The output channel (out_valid/out_ready) presents tree_index,
//   branch_length and path_bits until the receiver takes the word.
//   From acceptance to a valid result the block runs a bit scan for the
//   forest height (one bit per cycle from the top, so short for tall
//   forests), a scan of the node's run of ones (one bit per cycle), and
//   the row walk, one row per cycle through a single shared compare and
//   subtract unit. These scans set the item rate.
//   A new word may be accepted while the previous result still waits; if
//   the receiver stalls, the sequencer holds in its final step until the
//   output register is free, and no new word is accepted meanwhile.
//   Reset (rst_n low) returns the sequencer to idle and drops out_valid.
// ----------------------------------------------------------------------------
module forest_position_offset #(
    parameter int POS_BITS = fpo_pkg::POS_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [fpo_pkg::NODE_W-1:0]   node_pos,
    input  logic [fpo_pkg::NODE_W-1:0]   leaf_count,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [fpo_pkg::IDX_W-1:0]    tree_index,
    output logic [fpo_pkg::IDX_W-1:0]    branch_length,
    output logic [fpo_pkg::NODE_W-1:0]   path_bits
);
    import fpo_pkg::*;

    localparam int HW = $clog2(POS_BITS);
    localparam int CW = $clog2(POS_BITS + 1);

    localparam logic [NODE_W-1:0]   LEAF_MAX_W = NODE_W'(1) << (POS_BITS - 1);
    localparam logic [POS_BITS-1:0] LEAF_MAX_P = POS_BITS'(1) << (POS_BITS - 1);
    localparam logic [HW-1:0]       TOP_IDX    = HW'(POS_BITS - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_HGT  = 3'd2;
    localparam logic [2:0] S_ROW  = 3'd3;
    localparam logic [2:0] S_WALK = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]          state_reg,   state_next;
    logic [POS_BITS-1:0] pos_reg,     pos_next;
    logic [POS_BITS-1:0] leaves_reg,  leaves_next;
    logic [POS_BITS-1:0] scan_reg,    scan_next;
    logic [POS_BITS-1:0] marker_reg,  marker_next;
    logic [HW-1:0]       idx_reg,     idx_next;
    logic [HW-1:0]       height_reg,  height_next;
    logic [CW-1:0]       row_reg,     row_next;
    logic [IDX_W-1:0]    trees_reg,   trees_next;
    logic                special_reg, special_next;

    logic                out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]    tree_reg,      tree_next;
    logic [IDX_W-1:0]    branch_reg,    branch_next;
    logic [NODE_W-1:0]   path_reg,      path_next;

    logic [POS_BITS-1:0] step_marker;
    step_flags_t         step_flags;
    logic [POS_BITS-1:0] inv_pos;
    logic [POS_BITS-1:0] inv_marker;
    logic [CW-1:0]       br_diff;
    logic                out_free;

    fpo_step_unit #(
        .POS_BITS (POS_BITS),
        .HW       (HW),
        .CW       (CW)
    ) u_step (
        .marker     (marker_reg),
        .leaves     (leaves_reg),
        .height     (height_reg),
        .row        (row_reg),
        .marker_new (step_marker),
        .flags      (step_flags)
    );

    assign inv_pos    = ~pos_reg;
    assign inv_marker = ~marker_reg;
    assign br_diff    = CW'(height_reg) - row_reg;
    assign out_free   = !out_valid_reg || out_ready;

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign tree_index    = tree_reg;
    assign branch_length = branch_reg;
    assign path_bits     = path_reg;

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        leaves_next    = leaves_reg;
        scan_next      = scan_reg;
        marker_next    = marker_reg;
        idx_next       = idx_reg;
        height_next    = height_reg;
        row_next       = row_reg;
        trees_next     = trees_reg;
        special_next   = special_reg;
        out_valid_next = out_valid_reg && !out_ready;
        tree_next      = tree_reg;
        branch_next    = branch_reg;
        path_next      = path_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pos_next    = node_pos[POS_BITS-1:0];
                    leaves_next = (leaf_count > LEAF_MAX_W) ? LEAF_MAX_P
                                                            : leaf_count[POS_BITS-1:0];
                    state_next  = S_PREP;
                end
            end
            S_PREP:
            begin
                scan_next    = (leaves_reg == '0) ? '0 : leaves_reg - POS_BITS'(1);
                idx_next     = TOP_IDX;
                marker_next  = pos_reg;
                trees_next   = '0;
                row_next     = '0;
                special_next = 1'b0;
                state_next   = S_HGT;
            end
            S_HGT:
            begin
                // Height is the bit length of leaves - 1, found top bit first.
                if (scan_reg[idx_reg])
                begin
                    height_next = idx_reg + HW'(1);
                    idx_next    = idx_reg + HW'(1);
                    state_next  = S_ROW;
                end
                else if (idx_reg == '0)
                begin
                    height_next = '0;
                    state_next  = S_ROW;
                end
                else
                begin
                    idx_next = idx_reg - HW'(1);
                end
            end
            S_ROW:
            begin
                if (pos_reg[idx_reg])
                begin
                    row_next = row_reg + CW'(1);
                    if (idx_reg == '0)
                    begin
                        // Every bit up to the height is set: node sits above it.
                        special_next = 1'b1;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg - HW'(1);
                    end
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if ((CW'(height_reg) > row_reg) && !step_flags.stop)
                begin
                    if (step_flags.take)
                    begin
                        marker_next = step_marker;
                        trees_next  = trees_reg + IDX_W'(1);
                    end
                    height_next = height_reg - HW'(1);
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (special_reg)
                    begin
                        tree_next   = '0;
                        branch_next = '0;
                        path_next   = NODE_W'(inv_pos);
                    end
                    else
                    begin
                        tree_next   = trees_reg;
                        branch_next = IDX_W'(br_diff);
                        path_next   = NODE_W'(inv_marker);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        leaves_reg  <= leaves_next;
        scan_reg    <= scan_next;
        marker_reg  <= marker_next;
        idx_reg     <= idx_next;
        height_reg  <= height_next;
        row_reg     <= row_next;
        trees_reg   <= trees_next;
        special_reg <= special_next;
        tree_reg    <= tree_next;
        branch_reg  <= branch_next;
        path_reg    <= path_next;
    end

    // An accepted word always starts the sequence at the preparation step.
    a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_PREP))
        else $error("accepted word did not enter preparation step");

    // While scanning the run of ones, the probe index plus the run length is the height.
    a_row_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROW) |-> ((CW'(idx_reg) + row_reg) == CW'(height_reg)))
        else $error("row scan index out of step with height");

    // The row walk never runs for a node found above the forest height.
    a_walk_normal: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> !special_reg)
        else $error("row walk entered for node above height");

    // A new result appears only from the final sequencer step.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside final step");

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the forest position offset block. The testbench sends node position
// and leaf count words through a bursty sender and takes results through a
// receiver that stalls at random. It computes the expected tree index, branch
// length and path for every word it hands over, and compares the results in
// order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fpo_pkg::*;

    localparam int POS_BITS       = POS_BITS_DEFAULT;
    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_WORDS   = 1700;
    localparam int CHUNK_WORDS    = 425;
    localparam int SETTLE_CYCLES  = 2 * POS_BITS + 8;
    localparam int WATCHDOG_LIMIT = 5000;

    localparam logic [NODE_W-1:0] ONE      = {{(NODE_W-1){1'b0}}, 1'b1};
    localparam logic [NODE_W-1:0] POS_MASK = {NODE_W{1'b1}} >> (NODE_W - POS_BITS);
    localparam logic [NODE_W-1:0] LEAF_MAX = ONE << (POS_BITS - 1);

    typedef struct {
        logic [NODE_W-1:0] pos;
        logic [NODE_W-1:0] leaves;
    } query_t;

    typedef struct {
        logic [IDX_W-1:0]  tree;
        logic [IDX_W-1:0]  branch;
        logic [NODE_W-1:0] path;
    } node_loc_t;

    logic                clk;
    logic                rst_n         = 1'b0;
    logic                in_valid      = 1'b0;
    logic                in_ready;
    logic [NODE_W-1:0]   node_pos      = '0;
    logic [NODE_W-1:0]   leaf_count    = '0;
    logic                out_valid;
    logic                out_ready     = 1'b0;
    logic [IDX_W-1:0]    tree_index;
    logic [IDX_W-1:0]    branch_length;
    logic [NODE_W-1:0]   path_bits;

    query_t    pending_queries[$];
    node_loc_t expected_locs[$];

    logic      in_fire        = 1'b0;
    int        queued_words   = 0;
    int        accepted_words = 0;
    int        checked_locs   = 0;
    int        errors         = 0;
    int        idle_cycles    = 0;
    int        directed_words = 0;
    int        shaped_words   = 0;
    int        noise_words    = 0;
    int        drain_pauses   = 0;

    int        burst_left     = 0;
    int        gap_left       = 0;
    int        ready_pct      = 100;
    int        ready_hold     = 0;

    forest_position_offset #(
        .POS_BITS(POS_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .node_pos      (node_pos),
        .leaf_count    (leaf_count),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .tree_index    (tree_index),
        .branch_length (branch_length),
        .path_bits     (path_bits)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Expected location of a node: forest height from the leaf count, the
    // node's row from its run of ones, then a row walk from the top down.
    function automatic node_loc_t locate_node(logic [NODE_W-1:0] pos_in,
                                              logic [NODE_W-1:0] leaves_in);
        logic [NODE_W-1:0] pos;
        logic [NODE_W-1:0] leaves;
        logic [NODE_W-1:0] probe;
        logic [NODE_W-1:0] marker;
        logic [NODE_W-1:0] span;
        logic [NODE_W-1:0] row_span_size;
        int unsigned       height;
        int unsigned       row;
        int unsigned       trees;
        node_loc_t         loc;

        pos    = pos_in & POS_MASK;
        leaves = (leaves_in > LEAF_MAX) ? LEAF_MAX : leaves_in;
        height = 0;
        if (leaves != 0)
        begin
            for (int b = 0; b < NODE_W; b++)
            begin
                if (((leaves - ONE) >> b) != 0)
                    height = b + 1;
            end
        end

        row   = 0;
        probe = ONE << height;
        while ((pos & probe) != 0)
        begin
            probe = probe >> 1;
            row++;
        end

        if (row > height)
        begin
            loc.tree   = '0;
            loc.branch = '0;
            loc.path   = ~pos & POS_MASK;
            return loc;
        end

        trees  = 0;
        marker = pos;
        while (height > row)
        begin
            span          = (ONE << (height + 1)) - ONE;
            row_span_size = (ONE << height) & leaves;
            if ((((marker << row) & POS_MASK) & span) < row_span_size)
                break;
            if (row_span_size != 0)
            begin
                marker = (marker - row_span_size) & POS_MASK;
                trees++;
            end
            height--;
        end

        loc.tree   = IDX_W'(trees);
        loc.branch = IDX_W'(height - row);
        loc.path   = ~marker & POS_MASK;
        return loc;
    endfunction

    function automatic logic [NODE_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // A node that exists in a forest of random height: the row prefix of
    // ones followed by an index within that row.
    function automatic query_t shaped_query();
        int                h;
        int                r;
        logic [NODE_W-1:0] full;
        logic [NODE_W-1:0] row_nodes;
        query_t            q;

        h = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 6)
                                        : $urandom_range(0, POS_BITS - 1);
        if (h == 0)
            q.leaves = NODE_W'($urandom_range(0, 1));
        else
            q.leaves = (ONE << (h - 1)) + ONE + (rand_word() & ((ONE << (h - 1)) - ONE));
        r = $urandom_range(0, 1) ? $urandom_range(0, h)
                                 : $urandom_range(0, (h < 2) ? h : 2);
        full      = (ONE << (h + 1)) - ONE;
        row_nodes = q.leaves >> r;
        q.pos     = full ^ ((ONE << (h + 1 - r)) - ONE);
        if (row_nodes != 0)
        begin
            if ($urandom_range(0, 4) == 0)
                q.pos = q.pos + row_nodes - ONE;
            else
                q.pos = q.pos + rand_word() % row_nodes;
        end
        // Bits above the forest height should not matter.
        if ($urandom_range(0, 9) == 0)
            q.pos = q.pos | (rand_word() & ~full);
        return q;
    endfunction

    function automatic query_t noise_query();
        query_t q;

        q.pos = $urandom_range(0, 1) ? rand_word() : rand_word() >> $urandom_range(0, 63);
        case ($urandom_range(0, 3))
            0:       q.leaves = rand_word();
            1:       q.leaves = rand_word() >> $urandom_range(0, 63);
            2:       q.leaves = LEAF_MAX + (rand_word() >> $urandom_range(0, 63));
            default: q.leaves = NODE_W'($urandom_range(0, 9));
        endcase
        return q;
    endfunction

    task automatic queue_query(input logic [NODE_W-1:0] pos, input logic [NODE_W-1:0] leaves);
        query_t q;

        q.pos    = pos;
        q.leaves = leaves;
        pending_queries.insert(pending_queries.size(), q);
        queued_words++;
    endtask

    task automatic wait_for_drain();
        while (!(accepted_words == queued_words && expected_locs.size() == 0))
            @(posedge clk);
    endtask

    // Sender: bursts of words separated by idle gaps of random length.
    always @(negedge clk)
    begin : sender
        query_t q;

        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_fire)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_queries.size() > 0)
            begin
                q = pending_queries.pop_front();
                node_pos   <= q.pos;
                leaf_count <= q.leaves;
                in_valid   <= 1'b1;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 160);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: the ready rate is redrawn after a hold of random length.
    always @(negedge clk)
    begin : receiver
        if (ready_hold == 0)
        begin
            case ($urandom_range(0, 4))
                0, 1:    ready_pct = 100;
                2:       ready_pct = 75;
                3:       ready_pct = 40;
                default: ready_pct = 8;
            endcase
            ready_hold = $urandom_range(50, 400);
        end
        else
        begin
            ready_hold--;
        end
        out_ready <= ($urandom_range(1, 100) <= ready_pct);
    end

    always @(posedge clk)
    begin : monitor
        node_loc_t want;

        in_fire <= in_valid && in_ready;

        if (in_valid && in_ready)
        begin
            expected_locs.insert(expected_locs.size(), locate_node(node_pos, leaf_count));
            accepted_words++;
        end

        if (out_valid && out_ready)
        begin
            if (expected_locs.size() == 0)
            begin
                $display("%0t: result word with none expected, got index %0d branch %0d path %h",
                         $time, tree_index, branch_length, path_bits);
                errors++;
            end
            else
            begin
                want = expected_locs.pop_front();
                checked_locs++;
                if (tree_index !== want.tree)
                begin
                    $display("%0t: tree_index expected %0d, got %0d",
                             $time, want.tree, tree_index);
                    errors++;
                end
                if (branch_length !== want.branch)
                begin
                    $display("%0t: branch_length expected %0d, got %0d",
                             $time, want.branch, branch_length);
                    errors++;
                end
                if (path_bits !== want.path)
                begin
                    $display("%0t: path_bits expected %h, got %h",
                             $time, want.path, path_bits);
                    errors++;
                end
            end
        end

        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin : stimulus
        query_t q;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty, single-leaf and two-leaf forests.
        queue_query(64'h0, 64'h0);
        queue_query(64'h1, 64'h0);
        queue_query(64'h0, 64'h1);
        queue_query(64'h0, 64'h2);
        queue_query(64'h1, 64'h2);
        queue_query(64'h2, 64'h2);
        queue_query(64'h3, 64'h2);
        // Small forests with a lone tree and upper rows.
        queue_query(64'h2, 64'h3);
        queue_query(64'h4, 64'h3);
        queue_query(64'h6, 64'h3);
        queue_query(64'h6, 64'h7);
        queue_query(64'hD, 64'h7);
        queue_query(64'hF, 64'h5);
        queue_query(64'hF000_0000_0000_0005, 64'd100);
        // Largest forest, and leaf counts that saturate.
        queue_query(64'h0, LEAF_MAX);
        queue_query(LEAF_MAX - ONE, LEAF_MAX);
        queue_query(64'hFFFF_FFFF_FFFF_FFFE, LEAF_MAX);
        queue_query(64'hFFFF_FFFF_FFFF_FFFF, LEAF_MAX);
        queue_query(64'd12345, LEAF_MAX + ONE);
        queue_query(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_query(64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_query(LEAF_MAX - 64'd2, LEAF_MAX - ONE);
        queue_query(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        queue_query(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        directed_words = queued_words;

        // Queuing holds off between chunks until the block has fully drained.
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i % CHUNK_WORDS == 0)
            begin
                wait_for_drain();
                drain_pauses++;
            end
            if ($urandom_range(0, 99) < 75)
            begin
                q = shaped_query();
                shaped_words++;
            end
            else
            begin
                q = noise_query();
                noise_words++;
            end
            queue_query(q.pos, q.leaves);
        end

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (expected_locs.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, expected_locs.size());
            errors++;
        end

        $display("Checked %0d results: %0d corner words, %0d valid forest nodes, %0d raw words.",
                 checked_locs, directed_words, shaped_words, noise_words);
        $display("The sender waited for a full drain %0d times; %0d mismatches were seen.",
                 drain_pauses, errors);
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// File: files.f
rtl/core/fpo_pkg.sv
rtl/core/fpo_step_unit.sv
rtl/core/forest_position_offset.sv
dv/tb_top.sv
